@@ hw/rtl/mbrd_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrd_pkg
// Shared types and constants for the Modbus RTU read-registers master.
// ----------------------------------------------------------------------------
package mbrd_pkg;

    localparam int MAX_REGS = 32;
    localparam int IDX_W    = 5;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_RX      = 3'd1,
        ACT_TIMEOUT = 3'd2,
        ACT_DELAY   = 3'd3,
        ACT_TXFAIL  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        K_TX     = 2'd0,
        K_VALUE  = 2'd1,
        K_STATUS = 2'd2,
        K_RETRY  = 2'd3
    } kind_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_PARAM = 3'd1;
    localparam logic [2:0] ST_TX_ERR    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_BAD_RESP  = 3'd4;
    localparam logic [2:0] ST_CRC_ERR   = 3'd5;
    localparam logic [2:0] ST_EXCEPTION = 3'd6;

    localparam logic [2:0] CFG_ADDR  = 3'd0;
    localparam logic [2:0] CFG_FUNC  = 3'd1;
    localparam logic [2:0] CFG_FIRST = 3'd2;
    localparam logic [2:0] CFG_TOTAL = 3'd3;
    localparam logic [2:0] CFG_RETRY = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_EXC_CRC,
        PH_DATA,
        PH_RETRY
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TX,
        BK_VALUES,
        BK_FINAL
    } bstate_t;

    // command from front to back
    typedef struct packed {
        logic       send_req;
        logic       dump;
        logic       final_en;
        logic [1:0] final_kind;
        logic [2:0] final_status;
    } cmd_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

endpackage

@@ hw/rtl/mbrd_ram.sv @@
// ----------------------------------------------------------------------------
// mbrd_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module mbrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/mbrd_front.sv @@
// ----------------------------------------------------------------------------
// mbrd_front
// Accepts events, tracks the response frame, writes the value buffer and
// issues result commands to the back end.
// ----------------------------------------------------------------------------
module mbrd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [2:0]                 action,
    input  logic [7:0]                 rx_byte,
    input  logic [7:0]                 slave_address,
    input  logic [7:0]                 read_function,
    input  logic [15:0]                register_total,
    input  logic [7:0]                 retry_limit,
    input  logic                       q_full,
    output logic                       q_push,
    output mbrd_pkg::cmd_t             q_cmd,
    output logic                       we,
    output logic [mbrd_pkg::IDX_W-1:0] waddr,
    output logic [15:0]                wdata
);

    mbrd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  att_reg, att_next;
    logic [7:0]  held_reg, held_next;
    logic        mism_reg, mism_next;

    logic        acc;
    logic        rcv;
    logic [16:0] cnt;
    logic [16:0] off;
    logic [15:0] crc_b;
    logic [15:0] got;
    logic        bad;

    assign full  = q_full;
    assign acc   = push && !q_full;
    assign rcv   = phase_reg == mbrd_pkg::PH_HEADER || phase_reg == mbrd_pkg::PH_EXC_CRC
                   || phase_reg == mbrd_pkg::PH_DATA;
    assign cnt   = {register_total, 1'b0};
    assign off   = {9'd0, pos_reg} - 17'd3;
    assign crc_b = mbrd_pkg::crc_feed(crc_reg, rx_byte);
    assign got   = {rx_byte, held_reg};
    assign bad   = slave_address == 8'd0 || register_total == 16'd0
                   || register_total > 16'(mbrd_pkg::MAX_REGS)
                   || (read_function != 8'h03 && read_function != 8'h04);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mbrd_pkg::PH_IDLE;
            pos_reg   <= '0;
            crc_reg   <= 16'hFFFF;
            att_reg   <= '0;
            held_reg  <= '0;
            mism_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            att_reg   <= att_next;
            held_reg  <= held_next;
            mism_reg  <= mism_next;
        end
    end

    always_comb
    begin
        logic       do_fail;
        logic [2:0] code;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        att_next   = att_reg;
        held_next  = held_reg;
        mism_next  = mism_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        we         = 1'b0;
        waddr      = off[mbrd_pkg::IDX_W:1];
        wdata      = {held_reg, rx_byte};
        do_fail    = 1'b0;
        code       = mbrd_pkg::ST_OK;
        if (acc)
        begin
            unique case (action)
                mbrd_pkg::ACT_START:
                begin
                    att_next = '0;
                    pos_next = '0;
                    crc_next = 16'hFFFF;
                    held_next = '0;
                    mism_next = 1'b0;
                    q_push = 1'b1;
                    if (bad)
                    begin
                        phase_next = mbrd_pkg::PH_IDLE;
                        q_cmd.final_en = 1'b1;
                        q_cmd.final_kind = mbrd_pkg::K_STATUS;
                        q_cmd.final_status = mbrd_pkg::ST_BAD_PARAM;
                    end
                    else
                    begin
                        phase_next = mbrd_pkg::PH_HEADER;
                        q_cmd.send_req = 1'b1;
                    end
                end
                mbrd_pkg::ACT_RX:
                begin
                    priority case (phase_reg)
                        mbrd_pkg::PH_HEADER:
                        begin
                            crc_next = crc_b;
                            pos_next = pos_reg + 8'd1;
                            if (pos_reg == 8'd0)
                                mism_next = rx_byte != slave_address;
                            else if (pos_reg == 8'd1)
                                held_next = rx_byte;
                            else
                            begin
                                pos_next = 8'd3;
                                if (mism_reg)
                                begin
                                    do_fail = 1'b1;
                                    code = mbrd_pkg::ST_BAD_RESP;
                                end
                                else if (held_reg == (read_function | 8'h80))
                                    phase_next = mbrd_pkg::PH_EXC_CRC;
                                else if (held_reg != read_function
                                         || {9'd0, rx_byte} != cnt)
                                begin
                                    do_fail = 1'b1;
                                    code = mbrd_pkg::ST_BAD_RESP;
                                end
                                else
                                    phase_next = mbrd_pkg::PH_DATA;
                            end
                        end
                        mbrd_pkg::PH_EXC_CRC:
                        begin
                            if (pos_reg == 8'd3)
                            begin
                                held_next = rx_byte;
                                pos_next = 8'd4;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                code = (got == crc_reg) ? mbrd_pkg::ST_EXCEPTION
                                                        : mbrd_pkg::ST_CRC_ERR;
                            end
                        end
                        mbrd_pkg::PH_DATA:
                        begin
                            if (off < cnt)
                            begin
                                crc_next = crc_b;
                                pos_next = pos_reg + 8'd1;
                                if (!off[0])
                                    held_next = rx_byte;
                                else
                                    we = 1'b1;
                            end
                            else if (off == cnt)
                            begin
                                held_next = rx_byte;
                                pos_next = pos_reg + 8'd1;
                            end
                            else if (got != crc_reg)
                            begin
                                do_fail = 1'b1;
                                code = mbrd_pkg::ST_CRC_ERR;
                            end
                            else
                            begin
                                phase_next = mbrd_pkg::PH_IDLE;
                                pos_next = '0;
                                crc_next = 16'hFFFF;
                                q_push = 1'b1;
                                q_cmd.dump = 1'b1;
                                q_cmd.final_en = 1'b1;
                                q_cmd.final_kind = mbrd_pkg::K_STATUS;
                                q_cmd.final_status = mbrd_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                mbrd_pkg::ACT_TIMEOUT:
                begin
                    do_fail = rcv;
                    code = mbrd_pkg::ST_TIMEOUT;
                end
                mbrd_pkg::ACT_TXFAIL:
                begin
                    do_fail = rcv;
                    code = mbrd_pkg::ST_TX_ERR;
                end
                mbrd_pkg::ACT_DELAY:
                begin
                    if (phase_reg == mbrd_pkg::PH_RETRY)
                    begin
                        att_next = att_reg + 8'd1;
                        phase_next = mbrd_pkg::PH_HEADER;
                        pos_next = '0;
                        crc_next = 16'hFFFF;
                        held_next = '0;
                        mism_next = 1'b0;
                        q_push = 1'b1;
                        q_cmd.send_req = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (do_fail)
            begin
                pos_next = '0;
                crc_next = 16'hFFFF;
                q_push = 1'b1;
                q_cmd.final_en = 1'b1;
                q_cmd.final_status = code;
                if (att_reg < retry_limit)
                begin
                    phase_next = mbrd_pkg::PH_RETRY;
                    q_cmd.final_kind = mbrd_pkg::K_RETRY;
                end
                else
                begin
                    phase_next = mbrd_pkg::PH_IDLE;
                    q_cmd.final_kind = mbrd_pkg::K_STATUS;
                end
            end
        end
    end

endmodule

@@ hw/rtl/mbrd_back.sv @@
// ----------------------------------------------------------------------------
// mbrd_back
// Carries out commands: request bytes with CRC, buffered values, status.
// One output register holds the result beat until popped.
// ----------------------------------------------------------------------------
module mbrd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  mbrd_pkg::cmd_t             q_cmd,
    output logic                       q_pop,
    input  logic [7:0]                 slave_address,
    input  logic [7:0]                 read_function,
    input  logic [15:0]                first_register,
    input  logic [15:0]                register_total,
    output logic [mbrd_pkg::IDX_W-1:0] raddr,
    input  logic [15:0]                rdata,
    output logic                       values_busy,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 kind,
    output logic [7:0]                 tx_byte,
    output logic [4:0]                 reg_index,
    output logic [15:0]                reg_value,
    output logic [2:0]                 status,
    output logic                       last
);

    mbrd_pkg::bstate_t st_reg, st_next;
    mbrd_pkg::cmd_t    cmd_reg, cmd_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic        rd_reg, rd_next;
    logic        ov_reg, ov_next;
    logic [1:0]  ok_reg, ok_next;
    logic [7:0]  ob_reg, ob_next;
    logic [4:0]  oi_reg, oi_next;
    logic [15:0] ov16_reg, ov16_next;
    logic [2:0]  os_reg, os_next;
    logic        ol_reg, ol_next;

    logic        slot;
    logic [7:0]  rb;
    logic [5:0]  nreg;

    assign slot  = !ov_reg || pop;
    assign empty = !ov_reg;
    assign kind = ok_reg;
    assign tx_byte = ob_reg;
    assign reg_index = oi_reg;
    assign reg_value = ov16_reg;
    assign status = os_reg;
    assign last = ol_reg;
    assign raddr = cnt_reg[mbrd_pkg::IDX_W-1:0];
    assign nreg = register_total[5:0];
    assign values_busy = st_reg == mbrd_pkg::BK_VALUES;

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0: rb = slave_address;
            3'd1: rb = read_function;
            3'd2: rb = first_register[15:8];
            3'd3: rb = first_register[7:0];
            3'd4: rb = register_total[15:8];
            3'd5: rb = register_total[7:0];
            3'd6: rb = crc_reg[7:0];
            default: rb = crc_reg[15:8];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= mbrd_pkg::BK_IDLE;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            cmd_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            cnt_reg <= cnt_next;
            rd_reg <= rd_next;
            cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        ok_reg <= ok_next;
        ob_reg <= ob_next;
        oi_reg <= oi_next;
        ov16_reg <= ov16_next;
        os_reg <= os_next;
        ol_reg <= ol_next;
    end

    always_comb
    begin
        st_next = st_reg;
        cmd_next = cmd_reg;
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        rd_next = 1'b0;
        ov_next = ov_reg && !pop;
        ok_next = ok_reg;
        ob_next = ob_reg;
        oi_next = oi_reg;
        ov16_next = ov16_reg;
        os_next = os_reg;
        ol_next = ol_reg;
        q_pop = 1'b0;
        unique case (st_reg)
            mbrd_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_cmd;
                    cnt_next = '0;
                    crc_next = 16'hFFFF;
                    if (q_cmd.send_req)
                        st_next = mbrd_pkg::BK_TX;
                    else if (q_cmd.dump)
                        st_next = mbrd_pkg::BK_VALUES;
                    else
                        st_next = mbrd_pkg::BK_FINAL;
                end
            end
            mbrd_pkg::BK_TX:
            begin
                if (slot)
                begin
                    ov_next = 1'b1;
                    ok_next = mbrd_pkg::K_TX;
                    ob_next = rb;
                    oi_next = '0;
                    ov16_next = '0;
                    os_next = mbrd_pkg::ST_OK;
                    ol_next = cnt_reg == 6'd7;
                    if (cnt_reg < 6'd6)
                        crc_next = mbrd_pkg::crc_feed(crc_reg, rb);
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd7)
                        st_next = mbrd_pkg::BK_IDLE;
                end
            end
            mbrd_pkg::BK_VALUES:
            begin
                // read issued first, then the registered data is shown when the output slot is free
                if (!rd_reg)
                    rd_next = 1'b1;
                else if (slot)
                begin
                    ov_next = 1'b1;
                    ok_next = mbrd_pkg::K_VALUE;
                    ob_next = '0;
                    oi_next = cnt_reg[4:0];
                    ov16_next = rdata;
                    os_next = mbrd_pkg::ST_OK;
                    ol_next = 1'b0;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg + 6'd1 == nreg)
                        st_next = mbrd_pkg::BK_FINAL;
                end
                else
                    rd_next = 1'b1;
            end
            default:
            begin
                if (slot)
                begin
                    ov_next = 1'b1;
                    ok_next = cmd_reg.final_kind;
                    ob_next = '0;
                    oi_next = '0;
                    ov16_next = '0;
                    os_next = cmd_reg.final_status;
                    ol_next = 1'b1;
                    st_next = mbrd_pkg::BK_IDLE;
                end
            end
        endcase
    end

endmodule

@@ hw/rtl/modbus_rtu_read_registers_master_core.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_registers_master_core
// Modbus RTU master for function 3/4 reads: request, response check, values.
// ----------------------------------------------------------------------------
// The front end takes one event per cycle while it is not held. Commands
// that produce results go through a two-entry queue to the back end, which
// takes each command and then emits result beats: for a request, eight
// beats at one per cycle while the output slot is free; for a good read,
// one beat per buffered value, each read before it is shown, then one
// status beat; one beat for a status. full is raised while the queue is full
// and while a good read's values are still being drained from the buffer.
module modbus_rtu_read_registers_master_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  action,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [4:0]  reg_index,
    output logic [15:0] reg_value,
    output logic [2:0]  status,
    output logic        last
);

    logic [7:0]  addr_reg;
    logic [7:0]  func_reg;
    logic [15:0] first_reg;
    logic [15:0] total_reg;
    logic [7:0]  retry_reg;

    mbrd_pkg::cmd_t q_mem [2];
    logic q_wp_reg, q_rp_reg;
    logic [1:0] q_cnt_reg;
    logic q_full, q_push, q_pop, q_valid;
    mbrd_pkg::cmd_t q_in;

    logic dmp_reg;
    logic values_busy;
    logic f_full;

    logic we;
    logic [mbrd_pkg::IDX_W-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= 8'd1;
            func_reg  <= 8'd3;
            first_reg <= '0;
            total_reg <= 16'd1;
            retry_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mbrd_pkg::CFG_ADDR:  addr_reg  <= cfg_data[7:0];
                mbrd_pkg::CFG_FUNC:  func_reg  <= cfg_data[7:0];
                mbrd_pkg::CFG_FIRST: first_reg <= cfg_data;
                mbrd_pkg::CFG_TOTAL: total_reg <= cfg_data;
                mbrd_pkg::CFG_RETRY: retry_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign q_full  = q_cnt_reg == 2'd2;
    assign q_valid = q_cnt_reg != 2'd0;

    // hold the front while buffered values wait to be read out
    assign f_full  = q_full || dmp_reg || values_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= '0;
            dmp_reg   <= 1'b0;
        end
        else
        begin
            if (q_push)
                q_wp_reg <= !q_wp_reg;
            if (q_pop)
                q_rp_reg <= !q_rp_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
            if (q_push && q_in.dump)
                dmp_reg <= 1'b1;
            else if (q_pop && q_mem[q_rp_reg].dump)
                dmp_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wp_reg] <= q_in;
    end

    mbrd_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .action(action), .rx_byte(rx_byte),
        .slave_address(addr_reg), .read_function(func_reg),
        .register_total(total_reg), .retry_limit(retry_reg),
        .q_full(f_full), .q_push(q_push), .q_cmd(q_in),
        .we(we), .waddr(waddr), .wdata(wdata)
    );

    mbrd_ram #(.WIDTH(16), .DEPTH(mbrd_pkg::MAX_REGS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    mbrd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_mem[q_rp_reg]),
        .q_pop(q_pop), .slave_address(addr_reg), .read_function(func_reg),
        .first_register(first_reg), .register_total(total_reg),
        .raddr(raddr), .rdata(rdata), .values_busy(values_busy),
        .empty(empty), .pop(pop),
        .kind(kind), .tx_byte(tx_byte), .reg_index(reg_index),
        .reg_value(reg_value), .status(status), .last(last)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_cnt_reg != 2'd3)
        else $error("command queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
        else $error("push into full command queue");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty command queue");

endmodule

@@ test/tb_modbus_rtu_read_registers_master_core.sv @@
// ----------------------------------------------------------------------------
// tb_modbus_rtu_read_registers_master_core
// Self-checking bench for the Modbus RTU read master: a queue-fed driver and
// a clocked monitor compare every result beat with a local model of the
// request/response state machine across several register settings.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_read_registers_master_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] act;
        logic [7:0] b;
    } ev_t;

    typedef struct packed {
        logic [1:0]  k;
        logic [7:0]  tx;
        logic [4:0]  idx;
        logic [15:0] val;
        logic [2:0]  st;
        logic        lst;
    } res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  action = '0;
    logic [7:0]  rx_byte = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [4:0]  reg_index;
    logic [15:0] reg_value;
    logic [2:0]  status;
    logic        last;

    modbus_rtu_read_registers_master_core dut (.*);

    // model state
    logic [7:0]  m_addr = 8'd1, m_func = 8'd3, m_retry = 8'd0;
    logic [15:0] m_first = 16'd0, m_total = 16'd1;
    mbrd_pkg::phase_t m_ph = mbrd_pkg::PH_IDLE;
    logic [7:0]  m_pos = 8'd0, m_att = 8'd0, m_held = 8'd0;
    logic [15:0] m_crc = 16'hFFFF;
    logic        m_mis = 1'b0;
    logic [15:0] m_buf [mbrd_pkg::MAX_REGS];

    ev_t  item_q[$];
    res_t beat_q[$];
    int   errors = 0;
    int   idle_cnt = 0;
    int   in_gap = 0, out_gap = 0;
    logic full_s = 1'b1;

    initial forever #5 clk = ~clk;

    function automatic logic [15:0] crc8(logic [15:0] c, logic [7:0] d);
        c = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic void put(mbrd_pkg::kind_t k, logic [7:0] tx, logic [4:0] i,
                                logic [15:0] v, logic [2:0] s);
        res_t r;
        r = '{k, tx, i, v, s, 1'b0};
        beat_q.push_back(r);
    endfunction

    function automatic void send_req();
        logic [7:0]  rq [8];
        logic [15:0] c;
        c = 16'hFFFF;
        rq[0] = m_addr; rq[1] = m_func;
        rq[2] = m_first[15:8]; rq[3] = m_first[7:0];
        rq[4] = m_total[15:8]; rq[5] = m_total[7:0];
        for (int i = 0; i < 6; i++) c = crc8(c, rq[i]);
        rq[6] = c[7:0]; rq[7] = c[15:8];
        for (int i = 0; i < 8; i++)
            put(mbrd_pkg::K_TX, rq[i], 5'd0, 16'd0, mbrd_pkg::ST_OK);
        m_ph = mbrd_pkg::PH_HEADER; m_pos = 8'd0; m_crc = 16'hFFFF;
        m_held = 8'd0; m_mis = 1'b0;
    endfunction

    function automatic void fail_txn(logic [2:0] s);
        m_pos = 8'd0; m_crc = 16'hFFFF;
        if (m_att < m_retry) begin
            put(mbrd_pkg::K_RETRY, 8'd0, 5'd0, 16'd0, s); m_ph = mbrd_pkg::PH_RETRY;
        end else begin
            put(mbrd_pkg::K_STATUS, 8'd0, 5'd0, 16'd0, s); m_ph = mbrd_pkg::PH_IDLE;
        end
    endfunction

    function automatic void take(logic [7:0] b);
        int cnt, off;
        logic [15:0] got;
        cnt = m_total * 2;
        if (m_ph == mbrd_pkg::PH_HEADER) begin
            if (m_pos == 0) begin
                m_mis = (b != m_addr); m_crc = crc8(m_crc, b); m_pos++;
            end else if (m_pos == 1) begin
                m_held = b; m_crc = crc8(m_crc, b); m_pos++;
            end else begin
                m_crc = crc8(m_crc, b);
                if (m_mis) fail_txn(mbrd_pkg::ST_BAD_RESP);
                else if (m_held == (m_func | 8'h80)) begin
                    m_ph = mbrd_pkg::PH_EXC_CRC; m_pos = 8'd3;
                end else if (m_held != m_func || b != cnt) fail_txn(mbrd_pkg::ST_BAD_RESP);
                else begin
                    m_ph = mbrd_pkg::PH_DATA; m_pos = 8'd3;
                end
            end
        end else if (m_ph == mbrd_pkg::PH_EXC_CRC) begin
            if (m_pos == 3) begin
                m_held = b; m_pos = 8'd4;
            end else begin
                got = {b, m_held};
                fail_txn(got == m_crc ? mbrd_pkg::ST_EXCEPTION : mbrd_pkg::ST_CRC_ERR);
            end
        end else if (m_ph == mbrd_pkg::PH_DATA) begin
            off = m_pos - 3;
            if (off < cnt) begin
                m_crc = crc8(m_crc, b);
                if (off % 2 == 0) m_held = b;
                else m_buf[off / 2] = {m_held, b};
                m_pos++;
            end else if (off == cnt) begin
                m_held = b; m_pos++;
            end else begin
                got = {b, m_held};
                if (got != m_crc) fail_txn(mbrd_pkg::ST_CRC_ERR);
                else begin
                    for (int i = 0; i < m_total; i++)
                        put(mbrd_pkg::K_VALUE, 8'd0, 5'(i), m_buf[i], mbrd_pkg::ST_OK);
                    put(mbrd_pkg::K_STATUS, 8'd0, 5'd0, 16'd0, mbrd_pkg::ST_OK);
                    m_ph = mbrd_pkg::PH_IDLE; m_pos = 8'd0; m_crc = 16'hFFFF;
                end
            end
        end
    endfunction

    function automatic void predict(ev_t e);
        int n0;
        logic rcv;
        n0 = beat_q.size();
        rcv = (m_ph == mbrd_pkg::PH_HEADER || m_ph == mbrd_pkg::PH_EXC_CRC
               || m_ph == mbrd_pkg::PH_DATA);
        case (e.act)
            mbrd_pkg::ACT_START: begin
                m_att = 8'd0;
                if (m_addr == 0 || m_total == 0 || m_total > mbrd_pkg::MAX_REGS ||
                    (m_func != 8'h03 && m_func != 8'h04)) begin
                    m_ph = mbrd_pkg::PH_IDLE; m_pos = 8'd0; m_crc = 16'hFFFF;
                    put(mbrd_pkg::K_STATUS, 8'd0, 5'd0, 16'd0, mbrd_pkg::ST_BAD_PARAM);
                end else send_req();
            end
            mbrd_pkg::ACT_RX: if (rcv) take(e.b);
            mbrd_pkg::ACT_TIMEOUT: if (rcv) fail_txn(mbrd_pkg::ST_TIMEOUT);
            mbrd_pkg::ACT_DELAY: if (m_ph == mbrd_pkg::PH_RETRY) begin
                m_att++; send_req();
            end
            mbrd_pkg::ACT_TXFAIL: if (rcv) fail_txn(mbrd_pkg::ST_TX_ERR);
            default: ;
        endcase
        if (beat_q.size() > n0) beat_q[beat_q.size() - 1].lst = 1'b1;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] exp);
        $display("mismatch %s: got %0h exp %0h", what, got, exp);
        errors++;
    endtask

    function automatic int gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (push && !full_s) begin
                predict(item_q.pop_front());
                in_gap = gap();
            end
            if (in_gap > 0) begin
                in_gap--; push <= 1'b0;
            end else if (item_q.size() > 0) begin
                push <= 1'b1; action <= item_q[0].act; rx_byte <= item_q[0].b;
            end else push <= 1'b0;
            if (out_gap > 0) begin
                out_gap--; pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 7) == 0) out_gap = gap();
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        res_t e;
        int   ic;
        full_s <= full;
        if (rst_n) begin
            ic = idle_cnt + 1;
            if (push && !full) ic = 0;
            if (pop && !empty) begin
                ic = 0;
                if (beat_q.size() == 0) report("unexpected beat", 16'(kind), 16'd0);
                else begin
                    e = beat_q.pop_front();
                    if (kind !== e.k) report("kind", 16'(kind), 16'(e.k));
                    if (tx_byte !== e.tx) report("tx_byte", 16'(tx_byte), 16'(e.tx));
                    if (reg_index !== e.idx) report("reg_index", 16'(reg_index), 16'(e.idx));
                    if (reg_value !== e.val) report("reg_value", reg_value, e.val);
                    if (status !== e.st) report("status", 16'(status), 16'(e.st));
                    if (last !== e.lst) report("last", 16'(last), 16'(e.lst));
                end
            end
            idle_cnt <= ic;
            if (ic > 5000) begin
                $display("[modbus_rtu_read_registers_master_core] ERROR");
                $finish;
            end
        end
    end

    // response builders (bytes pushed onto item_q)
    function automatic void add(logic [2:0] a, logic [7:0] b);
        ev_t e;
        e = '{a, b};
        item_q.push_back(e);
    endfunction

    function automatic void add_resp(int mode);
        logic [7:0]  f [$];
        logic [15:0] c;
        int n;
        f.push_back(mode == 1 ? ~m_addr : m_addr);
        if (mode == 2) begin
            f.push_back(m_func | 8'h80); f.push_back(8'($urandom_range(1, 4)));
        end else begin
            n = m_total * 2;
            f.push_back(mode == 3 ? m_func ^ 8'h07 : m_func);
            f.push_back(8'(mode == 4 ? n + 2 : n));
            for (int i = 0; i < n; i++) f.push_back(8'($urandom));
        end
        c = 16'hFFFF;
        foreach (f[i]) c = crc8(c, f[i]);
        if (mode == 5) c = c ^ (16'h1 << $urandom_range(0, 15));
        f.push_back(c[7:0]); f.push_back(c[15:8]);
        foreach (f[i]) add(mbrd_pkg::ACT_RX, f[i]);
    endfunction

    task automatic wait_drain();
        while (item_q.size() > 0 || beat_q.size() > 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] i, logic [15:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1; cfg_index <= i; cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (i)
            mbrd_pkg::CFG_ADDR:  m_addr = d[7:0];
            mbrd_pkg::CFG_FUNC:  m_func = d[7:0];
            mbrd_pkg::CFG_FIRST: m_first = d;
            mbrd_pkg::CFG_TOTAL: m_total = d;
            mbrd_pkg::CFG_RETRY: m_retry = d[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_txns(int count);
        int r;
        for (int t = 0; t < count; t++) begin
            add(mbrd_pkg::ACT_START, 8'($urandom));
            r = $urandom_range(0, 19);
            if (r < 9) add_resp(0);
            else if (r < 14) begin
                add_resp($urandom_range(1, 5));
                if ($urandom_range(0, 1)) begin
                    add(mbrd_pkg::ACT_DELAY, 8'($urandom)); add_resp(0);
                end
            end else begin
                add(($urandom_range(0, 1)) ? mbrd_pkg::ACT_TIMEOUT : mbrd_pkg::ACT_TXFAIL,
                    8'($urandom));
                add(mbrd_pkg::ACT_DELAY, 8'($urandom));
                add(3'($urandom_range(0, 7)), 8'($urandom));
                add(mbrd_pkg::ACT_RX, 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // directed: reset settings, bad settings, exceptions, CRC error and retries, out-of-place events
        add(mbrd_pkg::ACT_RX, 8'hFF); add(mbrd_pkg::ACT_DELAY, 8'd0);
        add(3'd7, 8'd0); add(3'd5, 8'h00);
        add(mbrd_pkg::ACT_START, 8'd0); add_resp(0);
        add(mbrd_pkg::ACT_START, 8'd0); add_resp(2);
        add(mbrd_pkg::ACT_START, 8'd0); add(mbrd_pkg::ACT_RX, m_addr);
        add(mbrd_pkg::ACT_START, 8'd0); add_resp(0);
        wait_drain();
        cfg_write(mbrd_pkg::CFG_ADDR, 16'd0); add(mbrd_pkg::ACT_START, 8'd0); wait_drain();
        cfg_write(mbrd_pkg::CFG_ADDR, 16'h00FF); cfg_write(mbrd_pkg::CFG_FUNC, 16'h00FF);
        add(mbrd_pkg::ACT_START, 8'd0);
        wait_drain();
        cfg_write(mbrd_pkg::CFG_FUNC, 16'h0004); cfg_write(mbrd_pkg::CFG_TOTAL, 16'd0);
        add(mbrd_pkg::ACT_START, 8'd0);
        wait_drain();
        cfg_write(mbrd_pkg::CFG_TOTAL, 16'hFFFF); add(mbrd_pkg::ACT_START, 8'd0); wait_drain();
        cfg_write(mbrd_pkg::CFG_TOTAL, 16'd33); add(mbrd_pkg::ACT_START, 8'd0); wait_drain();
        cfg_write(mbrd_pkg::CFG_TOTAL, 16'd32); cfg_write(mbrd_pkg::CFG_FIRST, 16'hFFFF);
        cfg_write(mbrd_pkg::CFG_RETRY, 16'h00FF);
        add(mbrd_pkg::ACT_START, 8'd0); add_resp(5); add(mbrd_pkg::ACT_DELAY, 8'd0);
        add(mbrd_pkg::ACT_TIMEOUT, 8'd0);
        add(mbrd_pkg::ACT_DELAY, 8'd0); add(mbrd_pkg::ACT_TXFAIL, 8'd0);
        add(mbrd_pkg::ACT_DELAY, 8'd0); add_resp(0);
        wait_drain();
        // random phases with varying settings
        for (int p = 0; p < 6; p++) begin
            cfg_write(mbrd_pkg::CFG_ADDR, 16'((p == 5) ? 0 : $urandom_range(1, 255)));
            cfg_write(mbrd_pkg::CFG_FUNC, (p % 2) ? 16'h0003 : 16'h0004);
            cfg_write(mbrd_pkg::CFG_FIRST, 16'($urandom));
            cfg_write(mbrd_pkg::CFG_TOTAL, 16'((p == 3) ? 16 : $urandom_range(1, 4)));
            cfg_write(mbrd_pkg::CFG_RETRY, 16'((p == 2) ? 0 : $urandom_range(0, 3)));
            random_txns(p == 3 ? 1 : 2);
            wait_drain();
        end
        if (errors == 0)
            $display("[modbus_rtu_read_registers_master_core] OK");
        else
            $display("[modbus_rtu_read_registers_master_core] ERROR");
        $finish;
    end
endmodule
